// ===== rtl/core/obce_pkg.sv =====
package obce_pkg;

   // Input coordinate and axis formats
   localparam int CoordWidth    = 24;
   localparam int AxisFracBits  = 14;
   localparam int AxisCompWidth = 16;
   localparam int AxisCount     = 3;
   localparam int AxisRegWidth  = AxisCount * AxisCompWidth;

   // Projected values, min/max and results
   localparam int AccWidth = 27;

   // Datapath widths derived from the formats above
   localparam int ProdWidth = CoordWidth + AxisCompWidth;
   localparam int SumWidth  = ProdWidth + 2;
   localparam int ShWidth   = (SumWidth - AxisFracBits > AccWidth) ?
                              (SumWidth - AxisFracBits) : (AccWidth + 1);

   // Register file
   localparam int CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CsrAxisU = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrAxisV = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] CsrAxisW = CsrIndexWidth'(2);

   // Unit axes (1.0 in Q2.14) on x, y and z
   localparam logic [AxisRegWidth-1:0] AxisUReset = AxisRegWidth'(64'd16384);
   localparam logic [AxisRegWidth-1:0] AxisVReset = AxisRegWidth'(64'd1073741824);
   localparam logic [AxisRegWidth-1:0] AxisWReset = AxisRegWidth'(64'd70368744177664);

   typedef logic signed [CoordWidth-1:0]    coord_type;
   typedef logic signed [AccWidth-1:0]      acc_type;
   typedef logic        [AccWidth-1:0]      extent_type;
   typedef logic        [AxisRegWidth-1:0]  axis_type;
   typedef logic        [CsrIndexWidth-1:0] csr_index_type;

endpackage

// ===== rtl/core/obce_if.sv =====
interface obce_req_if import obce_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   logic      no_point;
   logic      last_item;

   modport source (output valid, point_x, point_y, point_z, no_point, last_item,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, no_point, last_item,
                   output ready);
endinterface

interface obce_rsp_if import obce_pkg::*; ();
   logic       valid;
   logic       ready;
   acc_type    center_u;
   acc_type    center_v;
   acc_type    center_w;
   extent_type width_u;
   extent_type width_v;
   extent_type width_w;

   modport source (output valid, center_u, center_v, center_w,
                   width_u, width_v, width_w,
                   input ready);
   modport sink   (input valid, center_u, center_v, center_w,
                   width_u, width_v, width_w,
                   output ready);
endinterface

interface obce_csr_if import obce_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   axis_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/oriented_box_center_width_core.sv =====
// Channel   | Dir | Payload                                   | Handshake
// ----------+-----+-------------------------------------------+-------------
// req_chan  | in  | point_x/y/z, no_point, last_item          | valid/ready
// rsp_chan  | out | center_u/v/w (signed), width_u/v/w        | valid/ready
// csr_chan  | in  | index (0 axis_u, 1 axis_v, 2 axis_w), data| valid/ready
//
// Throughput is one request per cycle unless a stalled rsp_chan holds req_chan.ready low.
// A result for the request marked last_item passes five registers: input, multiplier
// bank, projection, min/max tracking into the result snapshot, and output. Reset clears
// all valid bits and the tracking state and loads the unit axes. A stalled rsp_chan backs
// up the pipe only behind a result; requests that end no set drain through tracking.
// csr_chan is always ready.

module oriented_box_center_width_core import obce_pkg::*; (
   input logic       clock,
   input logic       reset,
   obce_req_if.sink   req_chan,
   obce_rsp_if.source rsp_chan,
   obce_csr_if.sink   csr_chan
);

   // ---------------------------------------------------------------------
   // Axis registers
   // ---------------------------------------------------------------------
   axis_type axis_ff [AxisCount];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= AxisUReset;
         axis_ff[1] <= AxisVReset;
         axis_ff[2] <= AxisWReset;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CsrAxisU: axis_ff[0] <= csr_chan.data;
            CsrAxisV: axis_ff[1] <= csr_chan.data;
            CsrAxisW: axis_ff[2] <= csr_chan.data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or its
   // content moves on. Only last_item requests need room downstream of
   // the tracking stage.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_nop_ff, s2_nop_ff, s3_nop_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff;

   logic out_free, s4_free, s3_go, s3_free, s2_free, s1_free, req_take;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      s4_free  = !s4_valid_ff || out_free;
      s3_go    = s3_valid_ff && (!s3_last_ff || s4_free);
      s3_free  = !s3_valid_ff || s3_go;
      s2_free  = !s2_valid_ff || s3_free;
      s1_free  = !s1_valid_ff || s2_free;
      req_take = req_chan.valid && s1_free;
   end

   assign req_chan.ready = s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff  <= req_take;
         if (s2_free) s2_valid_ff  <= s1_valid_ff;
         if (s3_free) s3_valid_ff  <= s2_valid_ff;
         if (s4_free) s4_valid_ff  <= s3_go && s3_last_ff;
         if (out_free) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: request register
   // ---------------------------------------------------------------------
   coord_type s1_coord_ff [AxisCount];

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_coord_ff[0] <= req_chan.point_x;
         s1_coord_ff[1] <= req_chan.point_y;
         s1_coord_ff[2] <= req_chan.point_z;
         s1_nop_ff      <= req_chan.no_point;
         s1_last_ff     <= req_chan.last_item;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: nine coordinate x axis-component products
   // prod[a][c] = coord[c] * axis[a].component[c]
   // ---------------------------------------------------------------------
   logic signed [ProdWidth-1:0] s2_prod_in [AxisCount][AxisCount];
   logic signed [ProdWidth-1:0] s2_prod_ff [AxisCount][AxisCount];

   always_comb begin
      for (int a = 0; a < AxisCount; a++) begin
         for (int c = 0; c < AxisCount; c++) begin
            s2_prod_in[a][c] = ProdWidth'(s1_coord_ff[c]) *
               ProdWidth'($signed(axis_ff[a][c*AxisCompWidth +: AxisCompWidth]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_free) begin
         s2_prod_ff <= s2_prod_in;
         s2_nop_ff  <= s1_nop_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: dot product, floor shift by the axis fraction, saturate
   // ---------------------------------------------------------------------
   localparam logic signed [ShWidth-1:0] SatMax =
      $signed({{(ShWidth-AccWidth+1){1'b0}}, {(AccWidth-1){1'b1}}});
   localparam logic signed [ShWidth-1:0] SatMin = ~SatMax;

   logic signed [SumWidth-1:0] dot_sum [AxisCount];
   logic signed [ShWidth-1:0]  dot_sh  [AxisCount];
   acc_type                    s3_proj_in [AxisCount];
   acc_type                    s3_proj_ff [AxisCount];

   always_comb begin
      for (int a = 0; a < AxisCount; a++) begin
         dot_sum[a] = SumWidth'(s2_prod_ff[a][0]) + SumWidth'(s2_prod_ff[a][1]) +
                      SumWidth'(s2_prod_ff[a][2]);
         dot_sh[a]  = ShWidth'(dot_sum[a] >>> AxisFracBits);
         if (dot_sh[a] > SatMax) begin
            s3_proj_in[a] = AccWidth'(SatMax);
         end else if (dot_sh[a] < SatMin) begin
            s3_proj_in[a] = AccWidth'(SatMin);
         end else begin
            s3_proj_in[a] = AccWidth'(dot_sh[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_free) begin
         s3_proj_ff <= s3_proj_in;
         s3_nop_ff  <= s2_nop_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Tracking: running min/max per axis. The first point of a set loads
   // both; a no_point request leaves them alone. seen_ff clears when a
   // set closes.
   // ---------------------------------------------------------------------
   acc_type low_ff  [AxisCount];
   acc_type high_ff [AxisCount];
   acc_type low_in  [AxisCount];
   acc_type high_in [AxisCount];
   logic    seen_ff;
   logic    seen_in;

   always_comb begin
      seen_in = seen_ff || !s3_nop_ff;
      for (int a = 0; a < AxisCount; a++) begin
         low_in[a]  = low_ff[a];
         high_in[a] = high_ff[a];
         if (!s3_nop_ff) begin
            if (!seen_ff || (s3_proj_ff[a] < low_ff[a])) low_in[a] = s3_proj_ff[a];
            if (!seen_ff || (s3_proj_ff[a] > high_ff[a])) high_in[a] = s3_proj_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         for (int a = 0; a < AxisCount; a++) begin
            low_ff[a]  <= '0;
            high_ff[a] <= '0;
         end
      end else if (s3_go) begin
         seen_ff <= seen_in && !s3_last_ff;
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: snapshot of the closed set
   // ---------------------------------------------------------------------
   acc_type s4_low_ff  [AxisCount];
   acc_type s4_high_ff [AxisCount];
   logic    s4_seen_ff;

   always_ff @(posedge clock) begin
      if (s3_go && s3_last_ff && s4_free) begin
         s4_low_ff  <= low_in;
         s4_high_ff <= high_in;
         s4_seen_ff <= seen_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output: center = floor((min+max)/2), width = max-min.
   // An empty set reports center 0 and width 1.
   // ---------------------------------------------------------------------
   logic signed [AccWidth:0] mid_sum  [AxisCount];
   logic signed [AccWidth:0] span     [AxisCount];
   acc_type                  center_in [AxisCount];
   extent_type               width_in  [AxisCount];
   acc_type                  center_ff [AxisCount];
   extent_type               width_ff  [AxisCount];

   always_comb begin
      for (int a = 0; a < AxisCount; a++) begin
         mid_sum[a] = (AccWidth+1)'(s4_low_ff[a]) + (AccWidth+1)'(s4_high_ff[a]);
         span[a]    = (AccWidth+1)'(s4_high_ff[a]) - (AccWidth+1)'(s4_low_ff[a]);
         if (s4_seen_ff) begin
            center_in[a] = AccWidth'(mid_sum[a] >>> 1);
            width_in[a]  = AccWidth'(span[a]);
         end else begin
            center_in[a] = '0;
            width_in[a]  = AccWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_valid_ff && out_free) begin
         center_ff <= center_in;
         width_ff  <= width_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.center_u = center_ff[0];
   assign rsp_chan.center_v = center_ff[1];
   assign rsp_chan.center_w = center_ff[2];
   assign rsp_chan.width_u  = width_ff[0];
   assign rsp_chan.width_v  = width_ff[1];
   assign rsp_chan.width_w  = width_ff[2];

endmodule

// ===== rtl/core/obce_checker.sv =====
module obce_checker import obce_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input acc_type    center_u,
   input acc_type    center_v,
   input acc_type    center_w,
   input extent_type width_u,
   input extent_type width_v,
   input extent_type width_w
);

   localparam logic signed [AccWidth+1:0] BoxMax =
      $signed({3'b000, {(AccWidth-1){1'b1}}});
   localparam logic signed [AccWidth+1:0] BoxMin = ~BoxMax;

   acc_type                    center [AxisCount];
   extent_type                 extent [AxisCount];
   logic signed [AccWidth+1:0] c_ext, w_ext, hi_est, lo_est;
   logic                       bounds_ok;

   // min = center - floor(width/2), max = center + ceil(width/2); both
   // must sit inside the projection range.
   always_comb begin
      center[0] = center_u;
      center[1] = center_v;
      center[2] = center_w;
      extent[0] = width_u;
      extent[1] = width_v;
      extent[2] = width_w;
      bounds_ok = 1'b1;
      c_ext     = '0;
      w_ext     = '0;
      hi_est    = '0;
      lo_est    = '0;
      for (int a = 0; a < AxisCount; a++) begin
         c_ext  = (AccWidth+2)'(center[a]);
         w_ext  = $signed({2'b00, extent[a]});
         hi_est = c_ext + ((w_ext + (AccWidth+2)'(1)) >>> 1);
         lo_est = c_ext - (w_ext >>> 1);
         if ((hi_est > BoxMax) || (lo_est < BoxMin)) bounds_ok = 1'b0;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(center_u) && $stable(width_w))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_min_latency: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset, 1) && !$past(reset, 2) &&
                           !$past(reset, 3) && !$past(reset, 4))
      else $error("result earlier than pipeline depth after reset");

   a_box_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> bounds_ok)
      else $error("center/width imply min or max outside range");

endmodule

bind oriented_box_center_width_core obce_checker u_obce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .center_u  (rsp_chan.center_u),
   .center_v  (rsp_chan.center_v),
   .center_w  (rsp_chan.center_w),
   .width_u   (rsp_chan.width_u),
   .width_v   (rsp_chan.width_v),
   .width_w   (rsp_chan.width_w)
);

// ===== tb/obce_box_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and csr channels. Keeps a shadow copy of the
// axis registers and the per-axis min/max, predicts one box per set and
// compares each result in order.
module obce_box_checker import obce_pkg::*; (
   input  logic clock,
   input  logic reset,
   obce_req_if  req,
   obce_rsp_if  rsp,
   obce_csr_if  csr,
   output int   fail_count,
   output int   pending_count
);

   localparam longint AccMax = (longint'(1) <<< (AccWidth - 1)) - 1;
   localparam longint AccMin = -(longint'(1) <<< (AccWidth - 1));

   typedef struct {
      acc_type    center[AxisCount];
      extent_type extent[AxisCount];
   } box_result_type;

   string          axis_names[AxisCount] = '{"u", "v", "w"};
   axis_type       axes[AxisCount];
   acc_type        box_lo[AxisCount];
   acc_type        box_hi[AxisCount];
   logic           seen_point;
   box_result_type expected_boxes[$];

   // dot product with Q2.14 axis, floor shift, clamp to the 27-bit range
   function automatic acc_type project_point(axis_type axis, coord_type x, coord_type y,
                                             coord_type z);
      logic signed [AxisCompWidth-1:0] ax, ay, az;
      longint dot;
      longint shifted;
      ax = axis[AxisCompWidth-1:0];
      ay = axis[2*AxisCompWidth-1:AxisCompWidth];
      az = axis[3*AxisCompWidth-1:2*AxisCompWidth];
      dot = longint'(x) * longint'(ax) + longint'(y) * longint'(ay) +
            longint'(z) * longint'(az);
      shifted = dot >>> AxisFracBits;
      if (shifted > AccMax) shifted = AccMax;
      else if (shifted < AccMin) shifted = AccMin;
      return acc_type'(shifted);
   endfunction

   always @(posedge clock) begin : watch
      box_result_type want;
      box_result_type got;
      acc_type        proj;
      if (reset) begin
         axes[0] = AxisUReset;
         axes[1] = AxisVReset;
         axes[2] = AxisWReset;
         for (int a = 0; a < AxisCount; a++) begin
            box_lo[a] = '0;
            box_hi[a] = '0;
         end
         seen_point = 1'b0;
         expected_boxes.delete();
         fail_count = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CsrAxisU: axes[0] = csr.data;
               CsrAxisV: axes[1] = csr.data;
               CsrAxisW: axes[2] = csr.data;
               default: ;
            endcase
         end

         if (req.valid && req.ready) begin
            if (!req.no_point) begin
               for (int a = 0; a < AxisCount; a++) begin
                  proj = project_point(axes[a], req.point_x, req.point_y, req.point_z);
                  if (!seen_point) begin
                     box_lo[a] = proj;
                     box_hi[a] = proj;
                  end else begin
                     if (proj < box_lo[a]) box_lo[a] = proj;
                     if (proj > box_hi[a]) box_hi[a] = proj;
                  end
               end
               seen_point = 1'b1;
            end
            if (req.last_item) begin
               for (int a = 0; a < AxisCount; a++) begin
                  if (seen_point) begin
                     want.center[a] = acc_type'((longint'(box_lo[a]) +
                                                 longint'(box_hi[a])) >>> 1);
                     want.extent[a] = extent_type'(longint'(box_hi[a]) -
                                                   longint'(box_lo[a]));
                  end else begin
                     // empty set
                     want.center[a] = '0;
                     want.extent[a] = extent_type'(1);
                  end
               end
               expected_boxes.push_back(want);
               seen_point = 1'b0;
            end
         end

         if (rsp.valid && rsp.ready) begin
            got.center[0] = rsp.center_u;
            got.center[1] = rsp.center_v;
            got.center[2] = rsp.center_w;
            got.extent[0] = rsp.width_u;
            got.extent[1] = rsp.width_v;
            got.extent[2] = rsp.width_w;
            if (expected_boxes.size() == 0) begin
               $error("result with no set pending: center_u %0d width_u %0d",
                      got.center[0], got.extent[0]);
               fail_count++;
            end else begin
               want = expected_boxes.pop_front();
               for (int a = 0; a < AxisCount; a++) begin
                  if (got.center[a] !== want.center[a]) begin
                     $error("center_%s mismatch: expected %0d, actual %0d",
                            axis_names[a], want.center[a], got.center[a]);
                     fail_count++;
                  end
                  if (got.extent[a] !== want.extent[a]) begin
                     $error("width_%s mismatch: expected %0d, actual %0d",
                            axis_names[a], want.extent[a], got.extent[a]);
                     fail_count++;
                  end
               end
            end
         end
      end
      pending_count = expected_boxes.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Top level: clock, one reset, request and csr stimulus, result-side
// stalls and the verdict. Result comparison lives in obce_box_checker.
module testbench import obce_pkg::*; ();

   // Unused csr index: writes there must leave every axis alone
   localparam csr_index_type CsrUnused = csr_index_type'(3);

   // Q2.14 axis components
   localparam logic [AxisCompWidth-1:0] CompZero     = 16'h0000;
   localparam logic [AxisCompWidth-1:0] CompPlusOne  = 16'h4000;
   localparam logic [AxisCompWidth-1:0] CompMinusOne = 16'hC000;
   localparam logic [AxisCompWidth-1:0] CompMax      = 16'h7FFF;
   localparam logic [AxisCompWidth-1:0] CompMin      = 16'h8000;

   localparam coord_type CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam coord_type CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

   // Pipe is 5 deep; let it empty before touching the axes
   localparam int DrainCycles  = 12;
   localparam int PhaseCount   = 6;
   localparam int PhaseQuota   = 110;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;

   // Sender burst state
   int   burst_left;
   bit   no_idle;

   obce_req_if req_if ();
   obce_rsp_if rsp_if ();
   obce_csr_if csr_if ();

   oriented_box_center_width_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   obce_box_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_if),
      .rsp           (rsp_if),
      .csr           (csr_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a handshake hangs
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Result-side ready: a stall pattern picked at random, renewed when its random run ends.
   // Modes: always ready, coin flip, periodic, rarely ready.
   initial begin : rsp_stall
      int mode;
      int left;
      rsp_if.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_if.ready <= (left % 4 == 0);
            default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   function automatic axis_type pack_axis(logic [AxisCompWidth-1:0] ax,
                                          logic [AxisCompWidth-1:0] ay,
                                          logic [AxisCompWidth-1:0] az);
      return {az, ay, ax};
   endfunction

   // Mostly unit, zero, extreme and small values, with a share of full-range ones
   function automatic logic [AxisCompWidth-1:0] rand_comp();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         1: return CompPlusOne;
         2: return CompMinusOne;
         3: return CompMax;
         4: return CompMin;
         5: return CompZero;
         6, 7: return AxisCompWidth'(int'($urandom_range(0, 4000)) - 2000);
         default: return AxisCompWidth'($urandom);
      endcase
   endfunction

   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(0, 6);
      case (pick)
         0: return CoordMax;
         1: return CoordMin;
         5: return coord_type'(int'($urandom_range(0, 10000)) - 5000);
         6: return coord_type'(int'($urandom_range(0, 2)) - 1);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Bursts of back-to-back requests separated by short random gaps; no gaps when no_idle is set
   function automatic int next_gap();
      if (no_idle) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(1, 24);
      return $urandom_range(1, 7);
   endfunction

   // valid stays high after acceptance so back-to-back requests never
   // drop and re-raise it in the same step
   task automatic send_point(input coord_type x, input coord_type y, input coord_type z,
                             input logic nop, input logic last);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.point_x   <= x;
      req_if.point_y   <= y;
      req_if.point_z   <= z;
      req_if.no_point  <= nop;
      req_if.last_item <= last;
      req_if.valid     <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_csr(input csr_index_type idx, input axis_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Drop valid, wait for every pending box, then let the pipe empty
   task automatic wait_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // One set: mostly short, some long, a few empty. Coordinates on
   // no_point requests are random junk that must be ignored.
   task automatic send_random_set(inout int sent);
      int kind;
      int len;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         len = $urandom_range(0, 3);
         repeat (len) send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b0);
         send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b1);
         sent += len + 1;
      end else begin
         len = (kind < 16) ? $urandom_range(16, 40) : $urandom_range(1, 10);
         repeat (len - 1)
            send_point(rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(0, 9) == 0, 1'b0);
         send_point(rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(0, 6) == 0, 1'b1);
         sent += len;
      end
   endtask

   initial begin : stimulus
      int sent;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.point_x   = '0;
      req_if.point_y   = '0;
      req_if.point_z   = '0;
      req_if.no_point  = 1'b0;
      req_if.last_item = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = CsrAxisU;
      csr_if.data      = '0;
      burst_left       = 0;
      no_idle          = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // ---- directed, reset axes: projections equal x, y, z ----
      // single point: zero width, center at the extreme
      send_point(CoordMax, CoordMax, CoordMax, 1'b0, 1'b1);
      // full-range box
      send_point(CoordMin, CoordMin, CoordMin, 1'b0, 1'b0);
      send_point(CoordMax, CoordMax, CoordMax, 1'b0, 1'b1);
      // empty set, alone and after a no_point request
      send_point(CoordMax, CoordMin, CoordMax, 1'b1, 1'b1);
      send_point(CoordMin, CoordMax, CoordMin, 1'b1, 1'b0);
      send_point(CoordMax, CoordMax, CoordMin, 1'b1, 1'b1);
      // set closed by a no_point request; its junk coordinates are ignored
      send_point(CoordMax, CoordMin, coord_type'(1), 1'b0, 1'b0);
      send_point(CoordMin, CoordMax, coord_type'(-1), 1'b1, 1'b0);
      send_point(CoordMin, CoordMin, CoordMax, 1'b1, 1'b1);
      // small mixed-sign points; min+max is even on every axis
      send_point(coord_type'(-1), coord_type'(-1), coord_type'(-1), 1'b0, 1'b0);
      send_point(coord_type'(0), coord_type'(0), coord_type'(0), 1'b0, 1'b0);
      send_point(coord_type'(1), coord_type'(1), coord_type'(1), 1'b0, 1'b0);
      send_point(coord_type'(-3), coord_type'(5), coord_type'(7), 1'b0, 1'b1);

      // axis change in the middle of a set: kept min/max survive,
      // new axis applies to the last point
      send_point(coord_type'(100), coord_type'(200), coord_type'(-300), 1'b0, 1'b0);
      send_point(coord_type'(-5000), coord_type'(7), coord_type'(9), 1'b0, 1'b0);
      wait_drain();
      write_csr(CsrAxisU, pack_axis(CompMinusOne, CompPlusOne, CompMax));
      send_point(coord_type'(12345), coord_type'(-6789), coord_type'(42), 1'b0, 1'b1);

      // ---- extreme axes, a zero axis and a write to the unused index ----
      wait_drain();
      write_csr(CsrAxisU, pack_axis(CompMax, CompMax, CompMax));
      write_csr(CsrAxisV, pack_axis(CompMin, CompMin, CompMin));
      write_csr(CsrAxisW, pack_axis(CompZero, CompZero, CompZero));
      write_csr(CsrUnused, {AxisRegWidth{1'b1}});
      send_point(CoordMax, CoordMax, CoordMax, 1'b0, 1'b0);
      send_point(CoordMin, CoordMin, CoordMin, 1'b0, 1'b0);
      send_point(CoordMin, CoordMax, coord_type'(0), 1'b0, 1'b0);
      send_point(CoordMax, CoordMin, CoordMin, 1'b0, 1'b1);
      send_point(CoordMax, CoordMax, CoordMax, 1'b0, 1'b1);

      // ---- random phases, fresh axes each time ----
      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_drain();
         if (phase == 3) begin
            write_csr(CsrAxisU, pack_axis(CompMin, CompMax, CompMin));
            write_csr(CsrAxisV, pack_axis(CompMax, CompMin, CompMax));
            write_csr(CsrAxisW, pack_axis(CompMin, CompMin, CompMax));
         end else begin
            write_csr(CsrAxisU, pack_axis(rand_comp(), rand_comp(), rand_comp()));
            write_csr(CsrAxisV, pack_axis(rand_comp(), rand_comp(), rand_comp()));
            write_csr(CsrAxisW, pack_axis(rand_comp(), rand_comp(), rand_comp()));
         end
         if (phase == 4) write_csr(CsrUnused, axis_type'({$urandom, $urandom}));
         // one phase runs without sender gaps
         no_idle = (phase == 2);
         sent = 0;
         while (sent < PhaseQuota) send_random_set(sent);
      end

      wait_drain();
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/obce_pkg.sv
rtl/core/obce_if.sv
rtl/core/oriented_box_center_width_core.sv
rtl/core/obce_checker.sv
tb/obce_box_checker.sv
tb/testbench.sv
